// ----- rtl/tsg_pkg.sv -----
// shared constants and codes for the triangle shape-gradient block
// no dependencies
package tsg_pkg;

    localparam int VERTEX_COUNT_DEF = 65536;
    localparam int COORD_BITS_DEF   = 24;
    localparam int FRAC_BITS_DEF    = 32;

    localparam int NODE_W = 17;
    localparam int COEF_W = 48;
    localparam int AREA_W = 52;
    localparam int LANES  = 6;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_ELEMENT = 1'b1;

endpackage

// ----- rtl/tsg_vertex_ram.sv -----
// one copy of the vertex store, one write port and one registered read port
// depends on nothing
module tsg_vertex_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 48
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tsg_div_lane.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on nothing
module tsg_div_lane #(
    parameter int NW = 25,
    parameter int FW = 32,
    parameter int DW = 51
) (
    input  logic               clk,
    input  logic               en,
    input  logic [NW-1:0]      num,
    input  logic [DW-1:0]      den,
    output logic [NW+FW-1:0]   quo
);

    localparam int QW = NW + FW;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] dvd_reg [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] dvd_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   r_sh;
        logic [DW:0]   r_sub;
        logic          ge;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign dvd_in = {num, {FW{1'b0}}};
            assign den_in = den;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvd_in = dvd_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            r_sh  = {rem_in, dvd_in[QW-1]};
            r_sub = r_sh - {1'b0, den_in};
            ge    = (r_sh >= {1'b0, den_in});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= ge ? r_sub[DW-1:0] : r_sh[DW-1:0];
                quo_reg[k] <= {quo_in[QW-2:0], ge};
                dvd_reg[k] <= {dvd_in[QW-2:0], 1'b0};
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

// ----- rtl/triangle_shape_gradients.sv -----
// triangle shape-function gradients: vertex store, area and six pipelined dividers
// throughput: one word per cycle while in_stall is low, loads and elements alike;
// the divider lanes retire one quotient bit per stage, so their length sets the latency
// reset: rst_n clears only the valid bits; the vertex store is undefined until loaded
// the whole pipeline holds while a finished result waits on out_stall
module triangle_shape_gradients #(
    parameter int VERTEX_COUNT = tsg_pkg::VERTEX_COUNT_DEF,
    parameter int COORD_BITS   = tsg_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS    = tsg_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic [tsg_pkg::NODE_W-1:0]    vertex_number,
    input  logic signed [COORD_BITS-1:0]  coord_x,
    input  logic signed [COORD_BITS-1:0]  coord_y,
    input  logic [tsg_pkg::NODE_W-1:0]    node_first,
    input  logic [tsg_pkg::NODE_W-1:0]    node_second,
    input  logic [tsg_pkg::NODE_W-1:0]    node_third,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [tsg_pkg::AREA_W-1:0] area_half_units,
    output logic signed [tsg_pkg::COEF_W-1:0] alpha_first,
    output logic signed [tsg_pkg::COEF_W-1:0] alpha_second,
    output logic signed [tsg_pkg::COEF_W-1:0] alpha_third,
    output logic signed [tsg_pkg::COEF_W-1:0] beta_first,
    output logic signed [tsg_pkg::COEF_W-1:0] beta_second,
    output logic signed [tsg_pkg::COEF_W-1:0] beta_third,
    output logic                          degenerate,
    output logic                          saturated
);

    localparam int AW    = $clog2(VERTEX_COUNT);
    localparam int CW    = COORD_BITS + 1;          // coordinate difference, signed
    localparam int PW    = 2 * CW;                  // product, signed
    localparam int DW    = PW + 1;                  // doubled area, signed
    localparam int QW    = CW + FRAC_BITS;          // full quotient
    localparam int LANES = tsg_pkg::LANES;
    localparam int COEF_W = tsg_pkg::COEF_W;
    localparam int AREA_W = tsg_pkg::AREA_W;
    localparam int CMP_W = ((QW > COEF_W) ? QW : COEF_W) + 1;

    // global advance: everything moves unless a result waits downstream
    logic en;
    logic accept;
    logic out_valid_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign en       = !in_stall;
    assign accept   = in_valid && en;

    // ---------------- vertex store: three copies, one per corner ----------------
    logic [31:0]   wr_m1;
    logic          wr_ok;
    logic [AW-1:0] wr_addr;
    logic [tsg_pkg::NODE_W-1:0] node_in [3];
    logic [AW-1:0] rd_addr [3];
    logic          rd_ok   [3];
    logic [2*COORD_BITS-1:0] rd_data [3];

    assign node_in[0] = node_first;
    assign node_in[1] = node_second;
    assign node_in[2] = node_third;

    assign wr_m1   = 32'(vertex_number) - 32'd1;
    assign wr_ok   = (vertex_number != '0) && (32'(vertex_number) <= 32'(VERTEX_COUNT));
    assign wr_addr = wr_m1[AW-1:0];

    for (genvar c = 0; c < 3; c++)
    begin : g_corner
        logic [31:0] n_m1;

        assign n_m1       = 32'(node_in[c]) - 32'd1;
        assign rd_addr[c] = n_m1[AW-1:0];
        assign rd_ok[c]   = (node_in[c] != '0) && (32'(node_in[c]) <= 32'(VERTEX_COUNT));

        tsg_vertex_ram #(
            .DEPTH (VERTEX_COUNT),
            .AW    (AW),
            .DW    (2 * COORD_BITS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (accept && (op == tsg_pkg::OP_LOAD) && wr_ok),
            .wr_addr (wr_addr),
            .wr_data ({coord_x, coord_y}),
            .rd_en   (en),
            .rd_addr (rd_addr[c]),
            .rd_data (rd_data[c])
        );
    end

    // ---------------- stage 1: store read, corner validity ----------------
    logic       s1_valid_reg;
    logic [2:0] s1_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= accept && (op == tsg_pkg::OP_ELEMENT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_ok_reg <= {rd_ok[2], rd_ok[1], rd_ok[0]};
        end
    end

    // ---------------- stage 2: coordinate differences ----------------
    // lanes 0..2 are alpha (y differences), 3..5 beta (x differences)
    logic signed [CW-1:0] xs [3];
    logic signed [CW-1:0] ys [3];
    logic signed [CW-1:0] diff_next [LANES];
    logic signed [CW-1:0] dy21_next;
    logic signed [CW-1:0] dx31_next;

    for (genvar c = 0; c < 3; c++)
    begin : g_coord
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;

        assign cx    = s1_ok_reg[c] ? rd_data[c][2*COORD_BITS-1:COORD_BITS] : '0;
        assign cy    = s1_ok_reg[c] ? rd_data[c][COORD_BITS-1:0] : '0;
        assign xs[c] = $signed({cx[COORD_BITS-1], cx});
        assign ys[c] = $signed({cy[COORD_BITS-1], cy});
    end

    assign diff_next[0] = ys[1] - ys[2];
    assign diff_next[1] = ys[2] - ys[0];
    assign diff_next[2] = ys[0] - ys[1];
    assign diff_next[3] = xs[2] - xs[1];
    assign diff_next[4] = xs[0] - xs[2];
    assign diff_next[5] = xs[1] - xs[0];
    assign dy21_next    = ys[1] - ys[0];
    assign dx31_next    = xs[2] - xs[0];

    logic                 s2_valid_reg;
    logic signed [CW-1:0] s2_diff_reg [LANES];
    logic signed [CW-1:0] s2_dy21_reg;
    logic signed [CW-1:0] s2_dx31_reg;

    // ---------------- stage 3: the two cross products ----------------
    logic                 s3_valid_reg;
    logic signed [CW-1:0] s3_diff_reg [LANES];
    logic signed [PW-1:0] s3_p_reg;
    logic signed [PW-1:0] s3_q_reg;

    // ---------------- stage 4: doubled area ----------------
    logic                 s4_valid_reg;
    logic signed [CW-1:0] s4_diff_reg [LANES];
    logic signed [DW-1:0] s4_d_reg;

    // ---------------- stage 5: magnitudes and signs for the dividers ----------------
    logic                 s5_valid_reg;
    logic [CW-1:0]        s5_num_reg [LANES];
    logic [LANES-1:0]     s5_neg_reg;
    logic [DW-1:0]        s5_den_reg;
    logic                 s5_degen_reg;
    logic [AREA_W-1:0]    s5_area_reg;

    logic [DW-1:0]        d_abs;
    logic [AREA_W+DW-1:0] d_ext;

    assign d_abs = s4_d_reg[DW-1] ? DW'(-s4_d_reg) : DW'(s4_d_reg);
    assign d_ext = {{AREA_W{s4_d_reg[DW-1]}}, s4_d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_dy21_reg <= dy21_next;
            s2_dx31_reg <= dx31_next;
            s3_p_reg    <= s2_diff_reg[5] * s2_diff_reg[1];
            s3_q_reg    <= s2_dy21_reg * s2_dx31_reg;
            s4_d_reg    <= DW'(s3_p_reg) - DW'(s3_q_reg);
            s5_den_reg  <= d_abs;
            s5_degen_reg <= (s4_d_reg == '0);
            s5_area_reg <= d_ext[AREA_W-1:0];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_diff
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_diff_reg[l] <= diff_next[l];
                s3_diff_reg[l] <= s2_diff_reg[l];
                s4_diff_reg[l] <= s3_diff_reg[l];
                s5_num_reg[l]  <= s4_diff_reg[l][CW-1] ? CW'(-s4_diff_reg[l])
                                                       : CW'(s4_diff_reg[l]);
                s5_neg_reg[l]  <= s4_diff_reg[l][CW-1] ^ s4_d_reg[DW-1];
            end
        end
    end

    // ---------------- divider lanes and their sideband ----------------
    logic [QW-1:0]     quo [LANES];
    logic              sb_valid_reg [QW];
    logic              sb_degen_reg [QW];
    logic [AREA_W-1:0] sb_area_reg  [QW];
    logic [LANES-1:0]  sb_neg_reg   [QW];

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        tsg_div_lane #(
            .NW (CW),
            .FW (FRAC_BITS),
            .DW (DW)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (s5_num_reg[l]),
            .den (s5_den_reg),
            .quo (quo[l])
        );
    end

    for (genvar k = 0; k < QW; k++)
    begin : g_sb
        logic              v_in;
        logic              g_in;
        logic [AREA_W-1:0] a_in;
        logic [LANES-1:0]  n_in;

        if (k == 0)
        begin : g_first
            assign v_in = s5_valid_reg;
            assign g_in = s5_degen_reg;
            assign a_in = s5_area_reg;
            assign n_in = s5_neg_reg;
        end
        else
        begin : g_next
            assign v_in = sb_valid_reg[k-1];
            assign g_in = sb_degen_reg[k-1];
            assign a_in = sb_area_reg[k-1];
            assign n_in = sb_neg_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sb_valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                sb_valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_degen_reg[k] <= g_in;
                sb_area_reg[k]  <= a_in;
                sb_neg_reg[k]   <= n_in;
            end
        end
    end

    // ---------------- output stage: clip, sign, degenerate case ----------------
    logic              last_degen;
    logic [LANES-1:0]  last_neg;
    logic [COEF_W-1:0] coef_next [LANES];
    logic [LANES-1:0]  clip;

    assign last_degen = sb_degen_reg[QW-1];
    assign last_neg   = sb_neg_reg[QW-1];

    for (genvar l = 0; l < LANES; l++)
    begin : g_coef
        logic [COEF_W-1:0] limit;
        logic [CMP_W-1:0]  q_ext;
        logic [COEF_W-1:0] mag;

        // negative results may reach one step further
        assign limit   = last_neg[l] ? {1'b1, {(COEF_W-1){1'b0}}}
                                     : {1'b0, {(COEF_W-1){1'b1}}};
        assign q_ext   = CMP_W'(quo[l]);
        assign clip[l] = (q_ext > CMP_W'(limit));
        assign mag     = clip[l] ? limit : q_ext[COEF_W-1:0];
        assign coef_next[l] = last_degen ? '0 : (last_neg[l] ? -mag : mag);
    end

    logic              degen_reg;
    logic              sat_reg;
    logic [AREA_W-1:0] area_reg;
    logic [COEF_W-1:0] coef_reg [LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= sb_valid_reg[QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degen_reg <= last_degen;
            sat_reg   <= !last_degen && (clip != '0);
            area_reg  <= sb_area_reg[QW-1];
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                coef_reg[l] <= coef_next[l];
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign area_half_units = $signed(area_reg);
    assign alpha_first     = $signed(coef_reg[0]);
    assign alpha_second    = $signed(coef_reg[1]);
    assign alpha_third     = $signed(coef_reg[2]);
    assign beta_first      = $signed(coef_reg[3]);
    assign beta_second     = $signed(coef_reg[4]);
    assign beta_third      = $signed(coef_reg[5]);
    assign degenerate      = degen_reg;
    assign saturated       = sat_reg;

endmodule

// ----- tb/tb.sv -----
// self-checking testbench for triangle_shape_gradients: directed table, then random words
// depends on rtl/tsg_pkg.sv and rtl/triangle_shape_gradients.sv
`timescale 1ns / 100ps

module tb;

    localparam int  CW               = tsg_pkg::COORD_BITS_DEF;
    localparam int  FW               = tsg_pkg::FRAC_BITS_DEF;
    localparam int  NODE_W           = tsg_pkg::NODE_W;
    localparam int  COEF_W           = tsg_pkg::COEF_W;
    localparam int  AREA_W           = tsg_pkg::AREA_W;
    localparam int  VERTEX_COUNT_DEF = tsg_pkg::VERTEX_COUNT_DEF;
    localparam int  RANDOM_WORDS = 700;
    localparam int  DRAIN_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 600000;

    // one expected result word
    typedef struct {
        logic signed [AREA_W-1:0] area;
        logic signed [COEF_W-1:0] alpha [3];
        logic signed [COEF_W-1:0] beta [3];
        logic                     degen;
        logic                     sat;
    } gradients_t;

    // one row of the directed table
    typedef struct {
        logic                   op;
        logic [NODE_W-1:0]      vn;
        logic signed [CW-1:0]   cx;
        logic signed [CW-1:0]   cy;
        logic [NODE_W-1:0]      corner [3];
        bit                     typed;
        gradients_t             want;
    } table_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = tsg_pkg::OP_LOAD;
    logic [NODE_W-1:0] vertex_number = '0;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic [NODE_W-1:0] node_first = '0;
    logic [NODE_W-1:0] node_second = '0;
    logic [NODE_W-1:0] node_third = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [AREA_W-1:0] area_half_units;
    logic signed [COEF_W-1:0] alpha_first, alpha_second, alpha_third;
    logic signed [COEF_W-1:0] beta_first, beta_second, beta_third;
    logic degenerate, saturated;

    // testbench copy of the vertex store and which entries hold a value
    logic signed [CW-1:0] mesh_x [int];
    logic signed [CW-1:0] mesh_y [int];
    int                   loaded_ids [$];

    gradients_t  pending_grads [$];
    table_row_t  stim_table [$];
    int          mismatches = 0;
    int          words_sent = 0;
    longint      cycles = 0;
    bit          long_hold_done = 1'b0;

    triangle_shape_gradients i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .vertex_number   (vertex_number),
        .coord_x         (coord_x),
        .coord_y         (coord_y),
        .node_first      (node_first),
        .node_second     (node_second),
        .node_third      (node_third),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .area_half_units (area_half_units),
        .alpha_first     (alpha_first),
        .alpha_second    (alpha_second),
        .alpha_third     (alpha_third),
        .beta_first      (beta_first),
        .beta_second     (beta_second),
        .beta_third      (beta_third),
        .degenerate      (degenerate),
        .saturated       (saturated)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** triangle_shape_gradients: FAILED **");
            $finish;
        end
    end

    function automatic bit in_range(logic [NODE_W-1:0] n);
        return n >= 1 && n <= VERTEX_COUNT_DEF;
    endfunction

    // diff * 2^FW / den, truncated toward zero, clipped to the coefficient range
    function automatic logic signed [COEF_W-1:0] gradient_coef(longint diff, longint den,
                                                               inout logic sat);
        bit neg;
        longint unsigned num_mag, den_mag, lim, quo;
        longint res;
        neg     = (diff < 0) != (den < 0);
        num_mag = (diff < 0) ? -diff : diff;
        den_mag = (den < 0) ? -den : den;
        lim     = (64'd1 << (COEF_W - 1)) - (neg ? 0 : 1);
        quo     = (num_mag << FW) / den_mag;
        if (quo > lim)
        begin
            sat = 1'b1;
            quo = lim;
        end
        res = neg ? -longint'(quo) : longint'(quo);
        return res[COEF_W-1:0];
    endfunction

    // element prediction from the current store contents
    function automatic gradients_t triangle_gradients(logic [NODE_W-1:0] corner [3]);
        gradients_t g;
        longint xs [3], ys [3];
        longint d;
        g.sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            // out-of-range corners read as the origin
            xs[k] = in_range(corner[k]) ? longint'(mesh_x[corner[k]]) : 0;
            ys[k] = in_range(corner[k]) ? longint'(mesh_y[corner[k]]) : 0;
        end
        d = (xs[1] - xs[0]) * (ys[2] - ys[0]) - (ys[1] - ys[0]) * (xs[2] - xs[0]);
        g.area  = d[AREA_W-1:0];
        g.degen = (d == 0);
        for (int k = 0; k < 3; k++)
        begin
            g.alpha[k] = '0;
            g.beta[k]  = '0;
        end
        if (d != 0)
        begin
            g.alpha[0] = gradient_coef(ys[1] - ys[2], d, g.sat);
            g.alpha[1] = gradient_coef(ys[2] - ys[0], d, g.sat);
            g.alpha[2] = gradient_coef(ys[0] - ys[1], d, g.sat);
            g.beta[0]  = gradient_coef(xs[2] - xs[1], d, g.sat);
            g.beta[1]  = gradient_coef(xs[0] - xs[2], d, g.sat);
            g.beta[2]  = gradient_coef(xs[1] - xs[0], d, g.sat);
        end
        return g;
    endfunction

    function automatic gradients_t flat_result(bit degen);
        gradients_t g;
        g.area  = '0;
        g.degen = degen;
        g.sat   = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            g.alpha[k] = '0;
            g.beta[k]  = '0;
        end
        return g;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        mismatches++;
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, field, got, want);
    endtask

    // --- sender side ---

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // offer one word and hold it until taken, then update the prediction
    task automatic send_word(table_row_t row);
        op            <= row.op;
        vertex_number <= row.vn;
        coord_x       <= row.cx;
        coord_y       <= row.cy;
        node_first    <= row.corner[0];
        node_second   <= row.corner[1];
        node_third    <= row.corner[2];
        in_valid      <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (row.op == tsg_pkg::OP_LOAD)
        begin
            if (in_range(row.vn))
            begin
                if (!mesh_x.exists(row.vn))
                    loaded_ids.push_back(row.vn);
                mesh_x[row.vn] = row.cx;
                mesh_y[row.vn] = row.cy;
            end
        end
        else if (row.typed)
            pending_grads.push_back(row.want);
        else
            pending_grads.push_back(triangle_gradients(row.corner));
    endtask

    task automatic idle_for(int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // numbers and coordinates arrive as int and are cut to the port widths here
    function automatic table_row_t load_row(int vn, int x, int y);
        table_row_t r;
        r.op = tsg_pkg::OP_LOAD;
        r.vn = NODE_W'(vn);
        r.cx = CW'(x);
        r.cy = CW'(y);
        r.corner[0] = NODE_W'($urandom);
        r.corner[1] = NODE_W'($urandom);
        r.corner[2] = NODE_W'($urandom);
        r.typed = 1'b0;
        r.want = flat_result(1'b0);
        return r;
    endfunction

    function automatic table_row_t element_row(int a, int b, int c);
        table_row_t r;
        r.op = tsg_pkg::OP_ELEMENT;
        r.vn = NODE_W'($urandom);
        r.cx = CW'($urandom);
        r.cy = CW'($urandom);
        r.corner[0] = NODE_W'(a);
        r.corner[1] = NODE_W'(b);
        r.corner[2] = NODE_W'(c);
        r.typed = 1'b0;
        r.want = flat_result(1'b0);
        return r;
    endfunction

    function automatic int random_corner();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 0;
        else if (r < 12)
            return $urandom_range(2 ** NODE_W - 1, VERTEX_COUNT_DEF + 1);
        return loaded_ids[$urandom_range(loaded_ids.size() - 1)];
    endfunction

    function automatic int random_coord();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return int'($urandom);
        else if (r < 80)
            return $signed($urandom_range(16)) - 8;
        else if (r < 90)
            return 2 ** (CW - 1) - 1;
        return -(2 ** (CW - 1));
    endfunction

    function automatic table_row_t random_row();
        table_row_t r;
        int vn;
        int a;
        int pick;
        pick = $urandom_range(99);
        if (loaded_ids.size() >= 3 && pick < 60)
        begin
            r = element_row(random_corner(), random_corner(), random_corner());
            // repeated corner gives a zero-area triangle
            if ($urandom_range(99) < 12)
                r.corner[$urandom_range(2)] = r.corner[$urandom_range(2)];
            return r;
        end
        if (pick < 65)
        begin
            // ignored loads, number 0 or beyond the store
            vn = ($urandom_range(1) == 1) ? 0
                 : $urandom_range(2 ** NODE_W - 1, VERTEX_COUNT_DEF + 1);
            return load_row(vn, random_coord(), random_coord());
        end
        vn = ($urandom_range(3) == 0) ? $urandom_range(VERTEX_COUNT_DEF, VERTEX_COUNT_DEF - 30)
             : $urandom_range(40, 1);
        if (loaded_ids.size() > 0 && $urandom_range(99) < 15)
        begin
            // near copy of an existing vertex: thin triangles, large coefficients
            a = loaded_ids[$urandom_range(loaded_ids.size() - 1)];
            return load_row(vn, int'(mesh_x[a]) + ($signed($urandom_range(2)) - 1),
                            int'(mesh_y[a]) + ($signed($urandom_range(2)) - 1));
        end
        return load_row(vn, random_coord(), random_coord());
    endfunction

    // stimulus: reset, directed table, random words, drain
    initial
    begin
        table_row_t row;
        gradients_t unit;
        int cmax, cmin;
        bit burst;
        cmax = 2 ** (CW - 1) - 1;
        cmin = -(2 ** (CW - 1));

        // unit right triangle: area 1, coefficients read straight off the corners
        unit = flat_result(1'b0);
        unit.area     = AREA_W'(1);
        unit.alpha[0] = COEF_W'(-(64'sd1 <<< FW));
        unit.alpha[1] = COEF_W'(64'sd1 <<< FW);
        unit.beta[0]  = COEF_W'(-(64'sd1 <<< FW));
        unit.beta[2]  = COEF_W'(64'sd1 <<< FW);

        stim_table.push_back(load_row(1, cmax, cmax));
        stim_table.push_back(load_row(VERTEX_COUNT_DEF, cmin, cmin));
        stim_table.push_back(load_row(2, cmin, cmax));
        stim_table.push_back(load_row(3, cmax, cmin));
        stim_table.push_back(load_row(4, 0, 0));
        stim_table.push_back(load_row(5, 1, 0));
        stim_table.push_back(load_row(6, 0, 1));
        stim_table.push_back(load_row(7, 0, 0));
        stim_table.push_back(load_row(8, cmax, 1));
        stim_table.push_back(load_row(9, cmax - 1, 1));
        // loads outside the store are dropped
        stim_table.push_back(load_row(0, cmax, cmin));
        stim_table.push_back(load_row(VERTEX_COUNT_DEF + 1, cmin, cmax));
        stim_table.push_back(load_row(2 ** NODE_W - 1, cmax, cmax));

        row = element_row(1, 1, 1);
        row.typed = 1'b1;
        row.want = flat_result(1'b1);
        stim_table.push_back(row);
        // all corners out of range collapse onto the origin
        row = element_row(0, VERTEX_COUNT_DEF + 1, 2 ** NODE_W - 1);
        row.typed = 1'b1;
        row.want = flat_result(1'b1);
        stim_table.push_back(row);
        row = element_row(4, 5, 6);
        row.typed = 1'b1;
        row.want = unit;
        stim_table.push_back(row);
        stim_table.push_back(element_row(4, 6, 5));
        stim_table.push_back(element_row(7, 8, 9));   // sliver, coefficients clip
        stim_table.push_back(element_row(9, 8, 7));
        stim_table.push_back(element_row(1, 2, 3));
        stim_table.push_back(element_row(VERTEX_COUNT_DEF, 1, 2));
        stim_table.push_back(element_row(3, 2, VERTEX_COUNT_DEF));
        stim_table.push_back(element_row(1, 3, 0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            send_word(stim_table[i]);
            idle_for(pick_gap());
        end

        burst = 1'b0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // every so often a run of back-to-back words
            if (n % 100 == 0)
                burst = ($urandom_range(1) == 1);
            send_word(random_row());
            idle_for(burst ? 0 : pick_gap());
        end
        in_valid <= 1'b0;

        while (pending_grads.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("** triangle_shape_gradients: PASSED **");
        else
            $display("** triangle_shape_gradients: FAILED **");
        $finish;
    end

    // --- receiver side ---

    // random stalls, quiet stretches, and one long hold so the pipeline backs up
    initial
    begin
        int r;
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && words_sent >= 150)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                long_hold_done = 1'b1;
                out_stall <= 1'b0;
            end
            else if (quiet > 0)
            begin
                quiet--;
                out_stall <= 1'b0;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 3)
                    quiet = $urandom_range(200, 50);
                if (r >= 97)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(40, 10)) @(posedge clk);
                    out_stall <= 1'b0;
                end
                else
                    out_stall <= (r >= 75);
            end
        end
    end

    // compare every taken result word with the oldest prediction
    always @(posedge clk)
    begin
        gradients_t exp_g;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_grads.size() == 0)
            begin
                // a result word with no element behind it
                report_mismatch("out_valid", 1, 0);
            end
            else
            begin
                exp_g = pending_grads.pop_front();
                if (area_half_units !== exp_g.area)
                    report_mismatch("area_half_units", area_half_units, exp_g.area);
                if (alpha_first !== exp_g.alpha[0])
                    report_mismatch("alpha_first", alpha_first, exp_g.alpha[0]);
                if (alpha_second !== exp_g.alpha[1])
                    report_mismatch("alpha_second", alpha_second, exp_g.alpha[1]);
                if (alpha_third !== exp_g.alpha[2])
                    report_mismatch("alpha_third", alpha_third, exp_g.alpha[2]);
                if (beta_first !== exp_g.beta[0])
                    report_mismatch("beta_first", beta_first, exp_g.beta[0]);
                if (beta_second !== exp_g.beta[1])
                    report_mismatch("beta_second", beta_second, exp_g.beta[1]);
                if (beta_third !== exp_g.beta[2])
                    report_mismatch("beta_third", beta_third, exp_g.beta[2]);
                if (degenerate !== exp_g.degen)
                    report_mismatch("degenerate", degenerate, exp_g.degen);
                if (saturated !== exp_g.sat)
                    report_mismatch("saturated", saturated, exp_g.sat);
            end
        end
    end

endmodule

// ----- filelist.f -----
rtl/tsg_pkg.sv
rtl/tsg_vertex_ram.sv
rtl/tsg_div_lane.sv
rtl/triangle_shape_gradients.sv
tb/tb.sv
